/* hw/rtl/gfp_pkg.sv */
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared constants and types for the gyro frame parser.
// ----------------------------------------------------------------------------
package gfp_pkg;

    localparam int FRAME_LEN  = 15;
    localparam int IDX_W      = 4;
    localparam int SUM_FIRST  = 2;
    localparam int SUM_LAST   = 13;
    localparam int WORD_FIRST = 3;
    localparam int WORD_BYTES = 10;
    localparam int HALF_TURN  = 18000;
    localparam int FULL_TURN  = 36000;
    localparam int TDATA_W    = 104;

    localparam logic [7:0] HEADER_BYTE = 8'hAA;

    // Frame end event from the assembler, raw little-endian words
    typedef struct packed {
        logic        done;
        logic        good;
        logic [15:0] angle_word;
        logic [15:0] rate_word;
        logic [15:0] ax_word;
        logic [15:0] ay_word;
        logic [15:0] az_word;
    } frame_t;

    typedef struct packed {
        logic               checksum_ok;
        logic signed [16:0] angle_raw;
        logic signed [16:0] rate_raw;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [16:0] relative_angle;
    } result_t;

endpackage

/* hw/rtl/gfp_assembler.sv */
// ----------------------------------------------------------------------------
// gfp_assembler
// Header hunt, byte position tracking, running checksum and payload capture.
// ----------------------------------------------------------------------------
module gfp_assembler
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    input  logic [7:0]     rx_byte,
    output gfp_pkg::frame_t frame
);
    import gfp_pkg::*;

    logic             in_frame_reg;
    logic             in_frame_next;
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       bytes_reg [WORD_BYTES];
    logic             last_byte;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        index_next    = index_reg;
        sum_next      = sum_reg;
        last_byte     = 1'b0;
        if (byte_valid)
        begin
            if (!in_frame_reg)
            begin
                index_next = '0;
                sum_next   = '0;
                if (rx_byte == HEADER_BYTE)
                begin
                    in_frame_next = 1'b1;
                    index_next    = IDX_W'(1);
                end
            end
            else if (index_reg == IDX_W'(FRAME_LEN - 1))
            begin
                // checksum byte: close the frame
                last_byte     = 1'b1;
                in_frame_next = 1'b0;
                index_next    = '0;
                sum_next      = '0;
            end
            else
            begin
                index_next = index_reg + IDX_W'(1);
                if (index_reg >= IDX_W'(SUM_FIRST) && index_reg <= IDX_W'(SUM_LAST))
                begin
                    sum_next = sum_reg + rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            index_reg    <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            index_reg    <= index_next;
            sum_reg      <= sum_next;
        end
    end

    // each payload byte register loads at its own frame position
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            if (byte_valid && in_frame_reg && index_reg == IDX_W'(WORD_FIRST + k))
            begin
                bytes_reg[k] <= rx_byte;
            end
        end
    end

    always_comb
    begin
        frame.done       = last_byte;
        frame.good       = (sum_reg == rx_byte);
        frame.angle_word = {bytes_reg[1], bytes_reg[0]};
        frame.rate_word  = {bytes_reg[3], bytes_reg[2]};
        frame.ax_word    = {bytes_reg[5], bytes_reg[4]};
        frame.ay_word    = {bytes_reg[7], bytes_reg[6]};
        frame.az_word    = {bytes_reg[9], bytes_reg[8]};
    end

endmodule

/* hw/rtl/gfp_tracker.sv */
// ----------------------------------------------------------------------------
// gfp_tracker
// Value registers, zero capture, relative angle wrap and result register.
// ----------------------------------------------------------------------------
module gfp_tracker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic             zero_request,
    input  gfp_pkg::frame_t  frame,
    input  logic             out_ready,
    output logic             out_valid,
    output gfp_pkg::result_t result
);
    import gfp_pkg::*;

    logic signed [16:0] angle_reg, angle_next, angle_dec;
    logic signed [16:0] rate_reg, rate_next, rate_dec;
    logic signed [15:0] ax_reg, ax_next;
    logic signed [15:0] ay_reg, ay_next;
    logic signed [15:0] az_reg, az_next;
    logic signed [16:0] zero_reg, zero_next;
    logic               pending_reg, pending_next, pending_now;
    logic               out_valid_reg, out_valid_next;
    logic signed [17:0] diff, wrapped;
    logic               update;
    result_t            result_reg, result_next;

    always_comb
    begin
        update    = frame.done && frame.good;
        angle_dec = 17'sd0 - $signed({frame.angle_word[15], frame.angle_word});
        rate_dec  = 17'sd0 - $signed({frame.rate_word[15], frame.rate_word});

        angle_next = update ? angle_dec : angle_reg;
        rate_next  = update ? rate_dec : rate_reg;
        ax_next    = update ? $signed(frame.ax_word) : ax_reg;
        ay_next    = update ? $signed(frame.ay_word) : ay_reg;
        az_next    = update ? $signed(frame.az_word) : az_reg;

        // a request on the closing word still counts for this frame
        pending_now  = pending_reg || (byte_valid && zero_request);
        pending_next = pending_now;
        zero_next    = zero_reg;
        if (frame.done && pending_now)
        begin
            zero_next    = angle_next;
            pending_next = 1'b0;
        end

        diff = $signed({angle_next[16], angle_next}) - $signed({zero_next[16], zero_next});
        if (diff > $signed(18'(HALF_TURN)))
        begin
            wrapped = diff - $signed(18'(FULL_TURN));
        end
        else if (diff < -$signed(18'(HALF_TURN)))
        begin
            wrapped = diff + $signed(18'(FULL_TURN));
        end
        else
        begin
            wrapped = diff;
        end

        result_next.checksum_ok    = frame.good;
        result_next.angle_raw      = angle_next;
        result_next.rate_raw       = rate_next;
        result_next.accel_x        = ax_next;
        result_next.accel_y        = ay_next;
        result_next.accel_z        = az_next;
        result_next.relative_angle = wrapped[16:0];

        if (frame.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg     <= '0;
            rate_reg      <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            az_reg        <= '0;
            zero_reg      <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            angle_reg     <= angle_next;
            rate_reg      <= rate_next;
            ax_reg        <= ax_next;
            ay_reg        <= ay_next;
            az_reg        <= az_next;
            zero_reg      <= zero_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.done)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

/* hw/rtl/gyro_frame_parser.sv */
// ----------------------------------------------------------------------------
// gyro_frame_parser
// Byte-stream gyro frame parser with checksum check and zero-referenced angle.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle while the result slot is empty or being drained.
// Output: the result word is valid in the cycle after the closing byte of a
// frame is accepted; one result per 15-byte frame, none otherwise.
// Reset: rst_n clears frame state, stored values, zero reference and the
// output valid flag; the block hunts for a header right after reset.
// ----------------------------------------------------------------------------
module gyro_frame_parser
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // rx_byte
    input  logic                         s_tuser,   // zero_request
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // angle_raw[16:0], rate_raw[33:17], accel_x[49:34], accel_y[65:50],
    // accel_z[81:66], relative_angle[98:82], zero fill[103:99]
    output logic [gfp_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tuser    // checksum_ok
);
    import gfp_pkg::*;

    logic    byte_valid;
    frame_t  frame;
    result_t result;

    // take a new word while the result slot is empty or being drained
    assign s_tready   = !m_tvalid || m_tready;
    assign byte_valid = s_tvalid && s_tready;

    gfp_assembler u_assembler
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .rx_byte    (s_tdata),
        .frame      (frame)
    );

    gfp_tracker u_tracker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .zero_request (s_tuser),
        .frame        (frame),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .result       (result)
    );

    assign m_tdata = {5'b0, result.relative_angle, result.accel_z, result.accel_y,
                      result.accel_x, result.rate_raw, result.angle_raw};
    assign m_tuser = result.checksum_ok;

endmodule
